// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AST_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define AST_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

// ===== rtl/rgbe_pkg.sv =====
package rgbe_pkg;

    // Operation codes carried through the queue.
    localparam logic [1:0] OP_FEED    = 2'd0;
    localparam logic [1:0] OP_DRAIN   = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;
    localparam logic [1:0] OP_NONE    = 2'd3;

    // Parser phases.
    localparam logic [2:0] PH_FIRST  = 3'd0;
    localparam logic [2:0] PH_FLAT   = 3'd1;
    localparam logic [2:0] PH_MARK   = 3'd2;
    localparam logic [2:0] PH_COUNT  = 3'd3;
    localparam logic [2:0] PH_RUNVAL = 3'd4;
    localparam logic [2:0] PH_LIT    = 3'd5;
    localparam logic [2:0] PH_DONE   = 3'd6;
    localparam logic [2:0] PH_ERR    = 3'd7;

    // Error codes.
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_WIDTH = 2'd1;
    localparam logic [1:0] ERR_COUNT = 2'd2;
    localparam logic [1:0] ERR_CAP   = 2'd3;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic       valid;
        logic [1:0] op;
        logic [7:0] data;
    } queue_head_t;

    typedef struct packed {
        logic [2:0] count;
    } q_stat_t;

endpackage

// ===== rtl/rgbe_if.sv =====
interface rgbe_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] data_byte;
    modport source (output valid, output action, output data_byte, input ready);
    modport sink (input valid, input action, input data_byte, output ready);
endinterface

interface rgbe_out_if;
    logic       valid;
    logic       ready;
    logic       pixel_valid;
    logic [7:0] red_mantissa;
    logic [7:0] green_mantissa;
    logic [7:0] blue_mantissa;
    logic [7:0] shared_exponent;
    logic       end_of_line;
    logic       end_of_image;
    logic       flat_mode;
    logic [1:0] error_code;
    modport source (output valid, output pixel_valid, output red_mantissa,
                    output green_mantissa, output blue_mantissa, output shared_exponent,
                    output end_of_line, output end_of_image, output flat_mode,
                    output error_code, input ready);
    modport sink (input valid, input pixel_valid, input red_mantissa,
                  input green_mantissa, input blue_mantissa, input shared_exponent,
                  input end_of_line, input end_of_image, input flat_mode,
                  input error_code, output ready);
endinterface

// ===== rtl/rgbe_front.sv =====
module rgbe_front (
    input  logic                 clk,
    input  logic                 rst_n,
    rgbe_in_if.sink              pix_in,
    input  logic                 pop,
    output rgbe_pkg::queue_head_t head,
    output rgbe_pkg::q_stat_t    stat
);
    import rgbe_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    logic [1:0]    op_mem [0:QUEUE_DEPTH-1];
    logic [7:0]    data_mem [0:QUEUE_DEPTH-1];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW:0]   count_reg, count_next;
    logic [1:0]    op_class;
    logic          push;
    logic          take;

    // Classify the action; unknown actions are accepted and dropped here.
    always_comb
    begin
        unique case (pix_in.action)
            2'd0:    op_class = OP_FEED;
            2'd1:    op_class = OP_DRAIN;
            2'd2:    op_class = OP_RESTART;
            default: op_class = OP_NONE;
        endcase
    end

    assign pix_in.ready = (count_reg < (PW+1)'(QUEUE_DEPTH));
    assign take         = pix_in.valid && pix_in.ready;
    assign push         = take && (op_class != OP_NONE);

    // Queue pointers and fill count.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PW+1)'(push) - (PW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            op_mem[wr_ptr_reg]   <= op_class;
            data_mem[wr_ptr_reg] <= pix_in.data_byte;
        end
    end

    assign head.valid  = (count_reg != '0);
    assign head.op     = op_mem[rd_ptr_reg];
    assign head.data   = data_mem[rd_ptr_reg];
    assign stat.count  = 3'(count_reg);

endmodule

// ===== rtl/rgbe_back.sv =====
module rgbe_back #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rgbe_pkg::queue_head_t head,
    output logic                  pop,
    input  logic [14:0]           image_width,
    input  logic [15:0]           image_height,
    rgbe_out_if.source            pix_out
);
    import rgbe_pkg::*;

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam logic [16:0] MAXW = 17'(MAX_WIDTH);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_RUN  = 2'd1;
    localparam logic [1:0] B_READ = 2'd2;

    logic [1:0]  bst_reg, bst_next;
    logic [2:0]  phase_reg, phase_next;
    logic [31:0] mk_reg, mk_next;
    logic [1:0]  mcnt_reg, mcnt_next;
    logic [1:0]  ch_reg, ch_next;
    logic [15:0] pos_reg, pos_next;
    logic [7:0]  lit_reg, lit_next;
    logic [7:0]  runp_reg, runp_next;
    logic [7:0]  runv_reg, runv_next;
    logic [15:0] dpos_reg, dpos_next;
    logic [15:0] line_reg, line_next;
    logic        lrdy_reg, lrdy_next;
    logic [1:0]  err_reg, err_next;
    logic        flat_reg, flat_next;
    logic        peol_reg, peol_next;
    logic        peoi_reg, peoi_next;
    logic        pzero_reg, pzero_next;

    logic        ov_reg, ov_next;
    logic        opv_reg, opv_next;
    logic [31:0] opx_reg, opx_next;
    logic        oeol_reg, oeol_next;
    logic        oeoi_reg, oeoi_next;
    logic        ofl_reg, ofl_next;
    logic [1:0]  oerr_reg, oerr_next;

    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic          re;
    logic [AW-1:0] raddr;
    logic [7:0]    rdata [0:3];

    logic [16:0] width_x;
    logic [16:0] newpos;
    logic [16:0] room;
    logic [16:0] cnt_n;
    logic [16:0] lnext;
    logic [16:0] dnext;
    logic [7:0]  b0, b1, b2;
    logic [15:0] mw;
    logic        eol, eoi, rle, bad;

    // Plane memories: one write per cycle, the four planes read together.
    for (genvar c = 0; c < 4; c++)
    begin : g_plane
        logic [7:0] mem [0:MAX_WIDTH-1];
        always_ff @(posedge clk)
        begin
            if (we && (ch_reg == 2'(c)))
                mem[waddr] <= wdata;
            if (re)
                rdata[c] <= mem[raddr];
        end
    end

    // Parser, run filler and drain control.
    always_comb
    begin
        bst_next   = bst_reg;
        phase_next = phase_reg;
        mk_next    = mk_reg;
        mcnt_next  = mcnt_reg;
        ch_next    = ch_reg;
        pos_next   = pos_reg;
        lit_next   = lit_reg;
        runp_next  = runp_reg;
        runv_next  = runv_reg;
        dpos_next  = dpos_reg;
        line_next  = line_reg;
        lrdy_next  = lrdy_reg;
        err_next   = err_reg;
        flat_next  = flat_reg;
        peol_next  = peol_reg;
        peoi_next  = peoi_reg;
        pzero_next = pzero_reg;
        ov_next    = ov_reg && !pix_out.ready;
        opv_next   = opv_reg;
        opx_next   = opx_reg;
        oeol_next  = oeol_reg;
        oeoi_next  = oeoi_reg;
        ofl_next   = ofl_reg;
        oerr_next  = oerr_reg;
        pop        = 1'b0;
        we         = 1'b0;
        waddr      = pos_reg[AW-1:0];
        wdata      = runv_reg;
        re         = 1'b0;
        raddr      = dpos_reg[AW-1:0];
        width_x    = {2'b00, image_width};
        newpos     = {1'b0, pos_reg} + 17'd1;
        room       = ({1'b0, pos_reg} < width_x) ? width_x - {1'b0, pos_reg} : 17'd0;
        cnt_n      = 17'd0;
        lnext      = {1'b0, line_reg} + 17'd1;
        dnext      = {1'b0, dpos_reg} + 17'd1;
        b0         = 8'd0;
        b1         = 8'd0;
        b2         = 8'd0;
        mw         = 16'd0;
        eol        = 1'b0;
        eoi        = 1'b0;
        rle        = 1'b0;
        bad        = 1'b0;

        unique case (bst_reg)
            B_IDLE:
            begin
                if (head.valid && (!ov_reg || pix_out.ready))
                begin
                    pop = 1'b1;
                    unique case (head.op)
                        OP_FEED:
                        begin
                            if (!(lrdy_reg || phase_reg == PH_DONE || phase_reg == PH_ERR))
                            begin
                                unique case (phase_reg)
                                    PH_FIRST, PH_MARK, PH_FLAT:
                                    begin
                                        mk_next   = {mk_reg[23:0], head.data};
                                        mcnt_next = mcnt_reg + 2'd1;
                                        if (mcnt_reg == 2'd3)
                                        begin
                                            b0  = mk_next[31:24];
                                            b1  = mk_next[23:16];
                                            b2  = mk_next[15:8];
                                            mw  = mk_next[15:0];
                                            rle = (image_width >= 15'd8) && (b0 == 8'd2)
                                                  && (b1 == 8'd2) && !b2[7];
                                            bad = (b0 != 8'd2) || (b1 != 8'd2) || b2[7]
                                                  || (mw != {1'b0, image_width});
                                            if (phase_reg == PH_FIRST && !rle)
                                            begin
                                                flat_next  = 1'b1;
                                                phase_next = PH_FLAT;
                                            end
                                            if (phase_reg == PH_FLAT
                                                || (phase_reg == PH_FIRST && !rle))
                                            begin
                                                // One flat pixel per four bytes.
                                                eol = newpos >= width_x;
                                                eoi = eol && (lnext >= {1'b0, image_height});
                                                ov_next   = 1'b1;
                                                opv_next  = 1'b1;
                                                opx_next  = mk_next;
                                                oeol_next = eol;
                                                oeoi_next = eoi;
                                                ofl_next  = 1'b1;
                                                oerr_next = ERR_NONE;
                                                if (eol)
                                                begin
                                                    pos_next  = 16'd0;
                                                    line_next = lnext[15:0];
                                                end
                                                else
                                                begin
                                                    pos_next = newpos[15:0];
                                                end
                                                if (eoi)
                                                    phase_next = PH_DONE;
                                            end
                                            else if (bad || (phase_reg == PH_FIRST
                                                     && {2'b00, image_width} > MAXW))
                                            begin
                                                // Marker fault: width first, then capacity.
                                                err_next   = bad ? ERR_WIDTH : ERR_CAP;
                                                phase_next = PH_ERR;
                                                ov_next    = 1'b1;
                                                opv_next   = 1'b0;
                                                opx_next   = 32'd0;
                                                oeol_next  = 1'b0;
                                                oeoi_next  = 1'b0;
                                                ofl_next   = flat_reg;
                                                oerr_next  = bad ? ERR_WIDTH : ERR_CAP;
                                            end
                                            else
                                            begin
                                                phase_next = PH_COUNT;
                                                ch_next    = 2'd0;
                                                pos_next   = 16'd0;
                                            end
                                        end
                                    end
                                    PH_COUNT:
                                    begin
                                        cnt_n = head.data[7] && (head.data[6:0] != 7'd0)
                                                ? {10'd0, head.data[6:0]}
                                                : {9'd0, head.data};
                                        if (cnt_n == 17'd0 || cnt_n > room)
                                        begin
                                            err_next   = ERR_COUNT;
                                            phase_next = PH_ERR;
                                            ov_next    = 1'b1;
                                            opv_next   = 1'b0;
                                            opx_next   = 32'd0;
                                            oeol_next  = 1'b0;
                                            oeoi_next  = 1'b0;
                                            ofl_next   = flat_reg;
                                            oerr_next  = ERR_COUNT;
                                        end
                                        else if (head.data > 8'd128)
                                        begin
                                            runp_next  = cnt_n[7:0];
                                            phase_next = PH_RUNVAL;
                                        end
                                        else
                                        begin
                                            lit_next   = cnt_n[7:0];
                                            phase_next = PH_LIT;
                                        end
                                    end
                                    PH_RUNVAL:
                                    begin
                                        runv_next  = head.data;
                                        phase_next = PH_COUNT;
                                        if (runp_reg != 8'd0)
                                            bst_next = B_RUN;
                                        else if (newpos - 17'd1 >= width_x)
                                        begin
                                            pos_next = 16'd0;
                                            lit_next = 8'd0;
                                            ch_next  = ch_reg + 2'd1;
                                            if (ch_reg == 2'd3)
                                            begin
                                                lrdy_next  = 1'b1;
                                                dpos_next  = 16'd0;
                                                phase_next = PH_MARK;
                                                mcnt_next  = 2'd0;
                                            end
                                        end
                                    end
                                    default:
                                    begin
                                        // Literal byte.
                                        we    = ({1'b0, pos_reg} < MAXW);
                                        wdata = head.data;
                                        if (lit_reg != 8'd0)
                                            lit_next = lit_reg - 8'd1;
                                        if (lit_reg <= 8'd1)
                                            phase_next = PH_COUNT;
                                        if (newpos >= width_x)
                                        begin
                                            pos_next   = 16'd0;
                                            lit_next   = 8'd0;
                                            phase_next = PH_COUNT;
                                            ch_next    = ch_reg + 2'd1;
                                            if (ch_reg == 2'd3)
                                            begin
                                                lrdy_next  = 1'b1;
                                                dpos_next  = 16'd0;
                                                phase_next = PH_MARK;
                                                mcnt_next  = 2'd0;
                                            end
                                        end
                                        else
                                        begin
                                            pos_next = newpos[15:0];
                                        end
                                    end
                                endcase
                            end
                        end
                        OP_DRAIN:
                        begin
                            if (!lrdy_reg)
                            begin
                                ov_next   = 1'b1;
                                opv_next  = 1'b0;
                                opx_next  = 32'd0;
                                oeol_next = 1'b0;
                                oeoi_next = 1'b0;
                                ofl_next  = flat_reg;
                                oerr_next = err_reg;
                            end
                            else
                            begin
                                // Start the plane read; the pixel is registered out from the B_READ state.
                                re         = 1'b1;
                                eol        = dnext >= width_x;
                                eoi        = eol && (lnext >= {1'b0, image_height});
                                peol_next  = eol;
                                peoi_next  = eoi;
                                pzero_next = ({1'b0, dpos_reg} >= MAXW);
                                dpos_next  = dnext[15:0];
                                bst_next   = B_READ;
                                if (eol)
                                begin
                                    lrdy_next = 1'b0;
                                    dpos_next = 16'd0;
                                    line_next = lnext[15:0];
                                    if (eoi)
                                        phase_next = PH_DONE;
                                end
                            end
                        end
                        OP_RESTART:
                        begin
                            phase_next = PH_FIRST;
                            mk_next    = 32'd0;
                            mcnt_next  = 2'd0;
                            ch_next    = 2'd0;
                            pos_next   = 16'd0;
                            lit_next   = 8'd0;
                            runp_next  = 8'd0;
                            dpos_next  = 16'd0;
                            line_next  = 16'd0;
                            err_next   = ERR_NONE;
                            lrdy_next  = 1'b0;
                            flat_next  = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            B_RUN:
            begin
                // One run byte written per cycle.
                we        = ({1'b0, pos_reg} < MAXW);
                runp_next = runp_reg - 8'd1;
                pos_next  = newpos[15:0];
                if (runp_reg == 8'd1)
                begin
                    bst_next = B_IDLE;
                    if (newpos >= width_x)
                    begin
                        pos_next = 16'd0;
                        lit_next = 8'd0;
                        ch_next  = ch_reg + 2'd1;
                        if (ch_reg == 2'd3)
                        begin
                            lrdy_next  = 1'b1;
                            dpos_next  = 16'd0;
                            phase_next = PH_MARK;
                            mcnt_next  = 2'd0;
                        end
                    end
                end
            end
            B_READ:
            begin
                ov_next   = 1'b1;
                opv_next  = 1'b1;
                opx_next  = pzero_reg ? 32'd0 : {rdata[0], rdata[1], rdata[2], rdata[3]};
                oeol_next = peol_reg;
                oeoi_next = peoi_reg;
                ofl_next  = flat_reg;
                oerr_next = ERR_NONE;
                bst_next  = B_IDLE;
            end
            default:
            begin
                bst_next = B_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bst_reg   <= B_IDLE;
            phase_reg <= PH_FIRST;
            mk_reg    <= '0;
            mcnt_reg  <= '0;
            ch_reg    <= '0;
            pos_reg   <= '0;
            lit_reg   <= '0;
            runp_reg  <= '0;
            dpos_reg  <= '0;
            line_reg  <= '0;
            lrdy_reg  <= 1'b0;
            err_reg   <= ERR_NONE;
            flat_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            bst_reg   <= bst_next;
            phase_reg <= phase_next;
            mk_reg    <= mk_next;
            mcnt_reg  <= mcnt_next;
            ch_reg    <= ch_next;
            pos_reg   <= pos_next;
            lit_reg   <= lit_next;
            runp_reg  <= runp_next;
            dpos_reg  <= dpos_next;
            line_reg  <= line_next;
            lrdy_reg  <= lrdy_next;
            err_reg   <= err_next;
            flat_reg  <= flat_next;
            ov_reg    <= ov_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        runv_reg  <= runv_next;
        peol_reg  <= peol_next;
        peoi_reg  <= peoi_next;
        pzero_reg <= pzero_next;
        opv_reg   <= opv_next;
        opx_reg   <= opx_next;
        oeol_reg  <= oeol_next;
        oeoi_reg  <= oeoi_next;
        ofl_reg   <= ofl_next;
        oerr_reg  <= oerr_next;
    end

    assign pix_out.valid           = ov_reg;
    assign pix_out.pixel_valid     = opv_reg;
    assign pix_out.red_mantissa    = opx_reg[31:24];
    assign pix_out.green_mantissa  = opx_reg[23:16];
    assign pix_out.blue_mantissa   = opx_reg[15:8];
    assign pix_out.shared_exponent = opx_reg[7:0];
    assign pix_out.end_of_line     = oeol_reg;
    assign pix_out.end_of_image    = oeoi_reg;
    assign pix_out.flat_mode       = ofl_reg;
    assign pix_out.error_code      = oerr_reg;

endmodule

// ===== rtl/rgbe_scanline_rle_decoder.sv =====
`include "assert_macros.svh"

// Radiance RGBE pixel-data decoder. Items on pix_in carry an action (feed a byte, drain a
// pixel, restart) and are queued by the front end, four deep, so input can keep flowing
// while results wait. The back end takes one queued item at a time; a run value byte then
// writes its stored bytes (up to 127 writes, one per cycle into the plane memories), and a
// drain of a ready line goes through the registered plane read before the next item. An
// item only leaves the queue while the result register is empty or being accepted, so a
// result that waits holds up the back end. Flat files produce a pixel on the feed that
// completes it; RLE files produce pixels only on drains. The line memory holds 4 x
// MAX_WIDTH bytes and is not cleared at reset.
module rgbe_scanline_rle_decoder #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    rgbe_in_if.sink     pix_in,
    rgbe_out_if.source  pix_out,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import rgbe_pkg::*;

    logic [14:0]  width_reg;
    logic [15:0]  height_reg;
    queue_head_t  head;
    q_stat_t      qstat;
    logic         pop;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 15'd8;
            height_reg <= 16'd1;
        end
        else if (cfg_we)
        begin
            if (cfg_index == 1'b0)
                width_reg <= cfg_data[14:0];
            else
                height_reg <= cfg_data;
        end
    end

    rgbe_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .pix_in (pix_in),
        .pop    (pop),
        .head   (head),
        .stat   (qstat)
    );

    rgbe_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .pop          (pop),
        .image_width  (width_reg),
        .image_height (height_reg),
        .pix_out      (pix_out)
    );

    // The queue never overfills and is only popped when it holds an item.
    `AST_IMP(a_q_bound, clk, rst_n, 1'b1, qstat.count <= 3'(QUEUE_DEPTH))
    `AST_IMP(a_pop_head, clk, rst_n, pop, head.valid)
    // A status result carries no pixel bytes or position flags.
    `AST_IMP(a_status_zero, clk, rst_n, pix_out.valid && !pix_out.pixel_valid, (pix_out.red_mantissa == 8'd0) && (pix_out.shared_exponent == 8'd0) && !pix_out.end_of_line && !pix_out.end_of_image)
    // A pixel never reports an error.
    `AST_IMP(a_pixel_clean, clk, rst_n, pix_out.valid && pix_out.pixel_valid, pix_out.error_code == ERR_NONE)

endmodule

// ===== sim/rgbe_scanline_rle_decoder_tb.sv =====
module rgbe_scanline_rle_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rgbe_pkg::*;

    localparam int MAXW       = 4096;
    localparam int SETTLE     = 300;
    localparam int STALL_MAX  = 5000;
    localparam int RAND_ITEMS = 750;

    typedef struct packed {
        logic       pv;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] expo;
        logic       eol;
        logic       eoi;
        logic       flat;
        logic [1:0] err;
    } pixel_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;

    rgbe_in_if  pix_in ();
    rgbe_out_if pix_out ();

    rgbe_scanline_rle_decoder u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_in    (pix_in.sink),
        .pix_out   (pix_out.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the decoder state.
    logic [7:0]    plane_mem [0:4*MAXW-1];
    int unsigned   img_w;
    int unsigned   img_h;
    logic [2:0]    phase;
    logic [31:0]   mark_bytes;
    int unsigned   mark_cnt;
    int unsigned   chan;
    int unsigned   pos;
    int unsigned   lit_left;
    int unsigned   run_left;
    int unsigned   drain_pos;
    int unsigned   line_no;
    logic [1:0]    err_latch;
    bit            line_full;
    bit            flat_stream;

    pixel_result_t pending_pixels[$];
    int            fail_count;
    int            items_sent;
    int            quiet_cycles;
    int            send_idle_pct;
    int            recv_idle_pct;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void clear_decoder();
        phase       = PH_FIRST;
        mark_bytes  = '0;
        mark_cnt    = 0;
        chan        = 0;
        pos         = 0;
        lit_left    = 0;
        run_left    = 0;
        drain_pos   = 0;
        line_no     = 0;
        err_latch   = ERR_NONE;
        line_full   = 1'b0;
        flat_stream = 1'b0;
    endfunction

    function automatic pixel_result_t make_result(logic pv, logic [31:0] px, logic eol,
                                                  logic eoi, logic [1:0] err);
        pixel_result_t r;
        r = '{pv, px[31:24], px[23:16], px[15:8], px[7:0], eol, eoi, flat_stream, err};
        return r;
    endfunction

    function automatic pixel_result_t raise_error(logic [1:0] code);
        err_latch = code;
        phase     = PH_ERR;
        return make_result(1'b0, '0, 1'b0, 1'b0, code);
    endfunction

    function automatic pixel_result_t flat_pixel();
        bit eol;
        bit eoi;
        eol = (pos + 1 >= img_w);
        eoi = eol && (line_no + 1 >= img_h);
        flat_pixel = make_result(1'b1, mark_bytes, eol, eoi, ERR_NONE);
        if (eol)
        begin
            pos = 0;
            line_no++;
        end
        else
            pos++;
        if (eoi)
            phase = PH_DONE;
    endfunction

    function automatic void store_byte(logic [7:0] b);
        if (pos < MAXW)
            plane_mem[chan*MAXW + pos] = b;
        pos++;
    endfunction

    // Moves on to the next plane, or marks the line complete.
    function automatic void close_plane();
        if (pos < img_w)
            return;
        pos      = 0;
        lit_left = 0;
        phase    = PH_COUNT;
        chan++;
        if (chan >= 4)
        begin
            chan      = 0;
            line_full = 1'b1;
            drain_pos = 0;
            phase     = PH_MARK;
            mark_cnt  = 0;
        end
    endfunction

    function automatic bit decode_byte(logic [7:0] b, output pixel_result_t r);
        int unsigned wid;
        int unsigned room;
        int unsigned n;
        bit          rle;
        if (line_full || phase == PH_DONE || phase == PH_ERR)
            return 1'b0;
        if (phase == PH_FIRST || phase == PH_MARK || phase == PH_FLAT)
        begin
            mark_bytes = {mark_bytes[23:0], b};
            mark_cnt++;
            if (mark_cnt < 4)
                return 1'b0;
            mark_cnt = 0;
            if (phase == PH_FLAT)
            begin
                r = flat_pixel();
                return 1'b1;
            end
            wid = mark_bytes[15:0];
            if (phase == PH_FIRST)
            begin
                rle = img_w >= 8 && img_w <= 32767 && mark_bytes[31:24] == 8'd2 &&
                      mark_bytes[23:16] == 8'd2 && !mark_bytes[15];
                if (!rle)
                begin
                    flat_stream = 1'b1;
                    phase       = PH_FLAT;
                    r           = flat_pixel();
                    return 1'b1;
                end
                if (wid != img_w)
                begin
                    r = raise_error(ERR_WIDTH);
                    return 1'b1;
                end
                if (img_w > MAXW)
                begin
                    r = raise_error(ERR_CAP);
                    return 1'b1;
                end
            end
            else if (mark_bytes[31:24] != 8'd2 || mark_bytes[23:16] != 8'd2 ||
                     mark_bytes[15] || wid != img_w)
            begin
                r = raise_error(ERR_WIDTH);
                return 1'b1;
            end
            phase = PH_COUNT;
            chan  = 0;
            pos   = 0;
            return 1'b0;
        end
        if (phase == PH_COUNT)
        begin
            room = (pos < img_w) ? img_w - pos : 0;
            if (b > 8'd128)
            begin
                n = b - 128;
                if (n > room)
                begin
                    r = raise_error(ERR_COUNT);
                    return 1'b1;
                end
                run_left = n;
                phase    = PH_RUNVAL;
            end
            else
            begin
                n = b;
                if (n == 0 || n > room)
                begin
                    r = raise_error(ERR_COUNT);
                    return 1'b1;
                end
                lit_left = n;
                phase    = PH_LIT;
            end
            return 1'b0;
        end
        if (phase == PH_RUNVAL)
        begin
            while (run_left > 0)
            begin
                store_byte(b);
                run_left--;
            end
            phase = PH_COUNT;
            close_plane();
            return 1'b0;
        end
        // Literal byte.
        store_byte(b);
        if (lit_left > 0)
            lit_left--;
        if (lit_left == 0)
            phase = PH_COUNT;
        close_plane();
        return 1'b0;
    endfunction

    function automatic logic [7:0] plane_byte(int unsigned c, int unsigned x);
        return (x >= MAXW) ? 8'd0 : plane_mem[c*MAXW + x];
    endfunction

    function automatic pixel_result_t drain_pixel();
        bit eol;
        bit eoi;
        if (!line_full)
            return make_result(1'b0, '0, 1'b0, 1'b0, err_latch);
        eol = (drain_pos + 1 >= img_w);
        eoi = eol && (line_no + 1 >= img_h);
        drain_pixel = make_result(1'b1, {plane_byte(0, drain_pos), plane_byte(1, drain_pos),
                                         plane_byte(2, drain_pos), plane_byte(3, drain_pos)},
                                  eol, eoi, ERR_NONE);
        drain_pos++;
        if (eol)
        begin
            line_full = 1'b0;
            drain_pos = 0;
            line_no++;
            if (eoi)
                phase = PH_DONE;
        end
    endfunction

    // Works out what one accepted item produces.
    function automatic void predict_item(logic [1:0] act, logic [7:0] b);
        pixel_result_t r;
        if (act == OP_FEED)
        begin
            if (decode_byte(b, r))
                pending_pixels.push_back(r);
        end
        else if (act == OP_DRAIN)
            pending_pixels.push_back(drain_pixel());
        else if (act == OP_RESTART)
            clear_decoder();
    endfunction

    // Sends one item, with a random gap in front of it.
    task automatic send_item(logic [1:0] act, logic [7:0] b);
        if ($urandom_range(99) < send_idle_pct)
        begin
            pix_in.valid <= 1'b0;
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
            @(posedge clk);
        end
        pix_in.valid     <= 1'b1;
        pix_in.action    <= act;
        pix_in.data_byte <= b;
        do
            @(posedge clk);
        while (!pix_in.ready);
        predict_item(act, b);
        items_sent++;
    endtask

    task automatic feed(logic [7:0] b);
        send_item(OP_FEED, b);
    endtask

    task automatic drain_n(int n);
        repeat (n)
            send_item(OP_DRAIN, 8'h00);
    endtask

    // Holds off until every expected result is out and the back end has settled.
    task automatic wait_quiet();
        pix_in.valid <= 1'b0;
        @(posedge clk);
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE)
            @(posedge clk);
    endtask

    task automatic set_geometry(int unsigned w, int unsigned h);
        wait_quiet();
        cfg_we    <= 1'b1;
        cfg_index <= 1'b0;
        cfg_data  <= 16'(w);
        @(posedge clk);
        img_w     = w & 32'h7fff;
        cfg_index <= 1'b1;
        cfg_data  <= 16'(h);
        @(posedge clk);
        img_h     = h & 32'hffff;
        cfg_we    <= 1'b0;
    endtask

    task automatic send_marker(int unsigned w);
        feed(8'd2);
        feed(8'd2);
        feed(8'(w >> 8));
        feed(8'(w));
    endtask

    // Encodes one scanline with random runs and literals, then reads it back.
    task automatic send_rle_line(int unsigned w, int unsigned max_run);
        int unsigned p;
        int unsigned n;
        send_marker(w);
        for (int c = 0; c < 4; c++)
        begin
            p = 0;
            while (p < w)
            begin
                if ($urandom_range(1))
                begin
                    n = $urandom_range(1, (w - p < max_run) ? w - p : max_run);
                    feed(8'(128 + n));
                    feed(8'($urandom));
                end
                else
                begin
                    n = $urandom_range(1, (w - p < 128) ? w - p : 128);
                    feed(8'(n));
                    repeat (n)
                        feed(8'($urandom));
                end
                p += n;
            end
        end
        drain_n(w);
    endtask

    task automatic test_flat_stream();
        set_geometry(2, 1);
        send_item(OP_RESTART, 8'h00);
        repeat (4) feed(8'h00);
        repeat (4) feed(8'hff);
        feed(8'h5a);
        drain_n(1);
        send_item(OP_NONE, 8'hff);
    endtask

    task automatic test_rle_lines();
        set_geometry(8, 2);
        send_item(OP_RESTART, 8'h00);
        send_marker(8);
        for (int c = 0; c < 4; c++)
        begin
            feed(8'd131);
            feed(8'hff);
            feed(8'd5);
            repeat (5) feed(8'($urandom));
        end
        // A byte sent while the line waits is dropped.
        feed(8'h33);
        drain_n(9);
        send_rle_line(8, 127);
        feed(8'h02);
        drain_n(1);
    endtask

    task automatic test_error_cases();
        set_geometry(8, 2);
        send_item(OP_RESTART, 8'h00);
        send_marker(9);
        feed(8'h00);
        drain_n(1);
        set_geometry(5000, 1);
        send_item(OP_RESTART, 8'h00);
        send_marker(5000);
        set_geometry(8, 2);
        send_item(OP_RESTART, 8'h00);
        send_marker(8);
        feed(8'd0);
        send_item(OP_RESTART, 8'h00);
        send_marker(8);
        feed(8'd137);
        send_item(OP_RESTART, 8'h00);
        send_rle_line(8, 127);
        feed(8'd2); feed(8'd3); feed(8'd0); feed(8'd8);
        drain_n(1);
    endtask

    task automatic test_register_extremes();
        set_geometry(32767, 65535);
        send_item(OP_RESTART, 8'h00);
        repeat (12) feed(8'($urandom));
        send_item(OP_RESTART, 8'h00);
        send_marker(32767);
        set_geometry(1, 1);
        send_item(OP_RESTART, 8'h00);
        send_marker(1);
        // A marker at full capacity is accepted and a long run starts the plane.
        set_geometry(MAXW, 1);
        send_item(OP_RESTART, 8'h00);
        send_marker(MAXW);
        feed(8'd255);
        feed(8'($urandom));
        drain_n(1);
    endtask

    // Mostly well-formed images, some flat streams, some broken streams.
    task automatic random_images(int n_items);
        int unsigned w;
        int unsigned h;
        int          target;
        target = items_sent + n_items;
        while (items_sent < target)
        begin
            case ($urandom_range(9))
                0, 1:
                begin
                    set_geometry($urandom_range(1, 6), $urandom_range(1, 3));
                    send_item(OP_RESTART, 8'h00);
                    repeat ($urandom_range(4, 30))
                        send_item(($urandom_range(9) == 0) ? OP_DRAIN : OP_FEED,
                                  8'($urandom));
                end
                2:
                begin
                    send_item(OP_RESTART, 8'h00);
                    repeat ($urandom_range(2, 12))
                        send_item(2'($urandom), 8'($urandom));
                end
                default:
                begin
                    w = $urandom_range(8, 20);
                    h = $urandom_range(1, 3);
                    set_geometry(w, h);
                    send_item(OP_RESTART, 8'h00);
                    for (int l = 0; l < h; l++)
                    begin
                        if ($urandom_range(19) == 0)
                            feed(8'($urandom));
                        send_rle_line(w, $urandom_range(0, 3) == 0 ? 127 : 6);
                    end
                    if ($urandom_range(3) == 0)
                        drain_n(1);
                end
            endcase
        end
    endtask

    // Result checker.
    always @(posedge clk)
    begin
        pixel_result_t got;
        pixel_result_t want;
        if (rst_n && pix_out.valid && pix_out.ready)
        begin
            got = '{pix_out.pixel_valid, pix_out.red_mantissa, pix_out.green_mantissa,
                    pix_out.blue_mantissa, pix_out.shared_exponent, pix_out.end_of_line,
                    pix_out.end_of_image, pix_out.flat_mode, pix_out.error_code};
            if (pending_pixels.size() == 0)
            begin
                $display("%0t: unexpected item %h", $realtime, got);
                fail_count++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (got.pv !== want.pv)
                    $display("%0t: pixel_valid exp %h got %h", $realtime, want.pv, got.pv);
                if (got.red !== want.red)
                    $display("%0t: red exp %h got %h", $realtime, want.red, got.red);
                if (got.green !== want.green)
                    $display("%0t: green exp %h got %h", $realtime, want.green, got.green);
                if (got.blue !== want.blue)
                    $display("%0t: blue exp %h got %h", $realtime, want.blue, got.blue);
                if (got.expo !== want.expo)
                    $display("%0t: exponent exp %h got %h", $realtime, want.expo, got.expo);
                if (got.eol !== want.eol)
                    $display("%0t: end_of_line exp %h got %h", $realtime, want.eol, got.eol);
                if (got.eoi !== want.eoi)
                    $display("%0t: end_of_image exp %h got %h", $realtime, want.eoi, got.eoi);
                if (got.flat !== want.flat)
                    $display("%0t: flat_mode exp %h got %h", $realtime, want.flat, got.flat);
                if (got.err !== want.err)
                    $display("%0t: error_code exp %h got %h", $realtime, want.err, got.err);
                if (got !== want)
                    fail_count++;
            end
        end
    end

    // Receiver stalls.
    always @(posedge clk)
        pix_out.ready <= ($urandom_range(99) >= recv_idle_pct);

    // Watchdog on cycles with no item moving on either side.
    always @(posedge clk)
    begin
        if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_MAX)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = 1'b0;
        cfg_data         = '0;
        pix_in.valid     = 1'b0;
        pix_in.action    = OP_NONE;
        pix_in.data_byte = '0;
        pix_out.ready    = 1'b0;
        fail_count       = 0;
        items_sent       = 0;
        quiet_cycles     = 0;
        send_idle_pct    = 32;
        recv_idle_pct    = 79;
        img_w            = 8;
        img_h            = 1;
        clear_decoder();
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_flat_stream();
        test_rle_lines();
        test_error_cases();
        test_register_extremes();
        random_images(RAND_ITEMS / 3);
        send_idle_pct = 79;
        recv_idle_pct = 32;
        random_images(RAND_ITEMS / 3);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_images(RAND_ITEMS / 3);

        wait_quiet();
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
